FILE: src/sha256_byte_stream_hasher_top_assert.svh
// ---------------------------------------------------------------------------
// sha256 byte stream hasher assertion macros
// clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// same-cycle implication
`define SHABSH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHABSH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/shabsh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shabsh_pkg
// shared types, codes and constant tables of the sha256 byte stream hasher
// ---------------------------------------------------------------------------
package shabsh_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int ROUND_COUNT = 64;
	localparam int DIGEST_WORDS = 8;
	localparam int LEN_FILL = 56;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int FILL_W = $clog2(BLOCK_BYTES);
	localparam int RND_W = $clog2(ROUND_COUNT);
	localparam int IDX_W = $clog2(DIGEST_WORDS);

	// request kinds
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	// source of a byte pushed into the block buffer
	localparam logic [1:0] SRC_DATA = 2'd0;
	localparam logic [1:0] SRC_MARK = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN  = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0]      digest_word;
		logic [IDX_W-1:0] word_index;
		logic             last_word;
	} rsp_t;

	typedef struct packed {
		logic             push;
		logic [1:0]       push_src;
		logic             count_add;
		logic             work_load;
		logic             round_en;
		logic             hash_add;
		logic             hash_init;
		logic [RND_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_len;
	} status_t;

	function automatic logic [31:0] init_h(input logic [IDX_W-1:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [RND_W-1:0] i);
		logic [31:0] r;
		case (i)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/shabsh_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shabsh_ctrl
// sequencer: byte intake, padding, round count and digest readout
// ---------------------------------------------------------------------------
module shabsh_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_type,
	output logic                       req_stall,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [shabsh_pkg::IDX_W-1:0] word_index,
	output logic                       last_word,
	input  shabsh_pkg::status_t        st,
	output shabsh_pkg::cmd_t           cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FOLD  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [1:0] PH_MARK = 2'd0;
	localparam logic [1:0] PH_ZERO = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [shabsh_pkg::RND_W-1:0] RND_LAST =
		shabsh_pkg::RND_W'(shabsh_pkg::ROUND_COUNT - 1);
	localparam logic [shabsh_pkg::IDX_W-1:0] IDX_LAST =
		shabsh_pkg::IDX_W'(shabsh_pkg::DIGEST_WORDS - 1);

	logic [2:0]                      state_q, state_d;
	logic [1:0]                      phase_q, phase_d;
	logic                            pad_q, pad_d;
	logic [shabsh_pkg::RND_W-1:0]    cnt_q, cnt_d;
	logic                            req_fire;

	assign req_stall  = (state_q != ST_IDLE);
	assign req_fire   = req_valid && !req_stall;
	assign rsp_valid  = (state_q == ST_OUT);
	assign word_index = cnt_q[shabsh_pkg::IDX_W-1:0];
	assign last_word  = (word_index == IDX_LAST);

	always_comb begin
		cmd      = '0;
		cmd.cnt  = cnt_q;
		state_d  = state_q;
		phase_d  = phase_q;
		pad_d    = pad_q;
		cnt_d    = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_type == shabsh_pkg::REQ_APPEND) begin
						cmd.push      = 1'b1;
						cmd.push_src  = shabsh_pkg::SRC_DATA;
						cmd.count_add = 1'b1;
						pad_d         = 1'b0;
						if (st.fill_last) begin
							cmd.work_load = 1'b1;
							cnt_d         = '0;
							state_d       = ST_ROUND;
						end
					end else begin
						pad_d   = 1'b1;
						phase_d = PH_MARK;
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				case (phase_q)
					PH_MARK: begin
						cmd.push     = 1'b1;
						cmd.push_src = shabsh_pkg::SRC_MARK;
						phase_d      = PH_ZERO;
					end
					PH_ZERO: begin
						if (st.fill_len) begin
							phase_d = PH_LEN;
							cnt_d   = '0;
						end else begin
							cmd.push     = 1'b1;
							cmd.push_src = shabsh_pkg::SRC_ZERO;
						end
					end
					PH_LEN: begin
						cmd.push     = 1'b1;
						cmd.push_src = shabsh_pkg::SRC_LEN;
						cnt_d        = cnt_q + 1'b1;
						if (cnt_q[shabsh_pkg::IDX_W-1:0] == IDX_LAST) begin
							phase_d = PH_DONE;
						end
					end
					default: begin
						phase_d = PH_DONE;
					end
				endcase
				// a pushed byte that completes the block starts a compression
				if (cmd.push && st.fill_last) begin
					cmd.work_load = 1'b1;
					cnt_d         = '0;
					state_d       = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == RND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.hash_add = 1'b1;
				if (!pad_q) begin
					state_d = ST_IDLE;
				end else if (phase_q == PH_DONE) begin
					cnt_d   = '0;
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (!rsp_stall) begin
					if (last_word) begin
						cmd.hash_init = 1'b1;
						pad_d         = 1'b0;
						state_d       = ST_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_MARK;
			pad_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			pad_q   <= pad_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: src/shabsh_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shabsh_dp
// block buffer as a sliding schedule window, round unit, chaining hash, bit count
// ---------------------------------------------------------------------------
module shabsh_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            data_byte,
	input  shabsh_pkg::cmd_t      cmd,
	output shabsh_pkg::status_t   st,
	output logic [31:0]           digest_word
);

	localparam logic [shabsh_pkg::FILL_W-1:0] FILL_LAST =
		shabsh_pkg::FILL_W'(shabsh_pkg::BLOCK_BYTES - 1);
	localparam logic [shabsh_pkg::FILL_W-1:0] FILL_LEN =
		shabsh_pkg::FILL_W'(shabsh_pkg::LEN_FILL);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [shabsh_pkg::FILL_W-1:0] fill_q;
	logic [63:0]                   count_q;
	logic [31:0]                   h_q [shabsh_pkg::DIGEST_WORDS];
	logic [31:0]                   v_q [shabsh_pkg::DIGEST_WORDS];
	logic [31:0]                   w_q [16];
	logic [7:0]                    push_byte;
	logic [2:0]                    len_sel;
	logic [31:0]                   w_next;
	logic [31:0]                   t1;
	logic [31:0]                   t2;
	logic [31:0]                   ea;
	logic [31:0]                   aa;

	assign st.fill_last = (fill_q == FILL_LAST);
	assign st.fill_len  = (fill_q == FILL_LEN);
	assign digest_word  = h_q[cmd.cnt[shabsh_pkg::IDX_W-1:0]];

	// big-endian bit count, most significant byte first
	assign len_sel = 3'd7 - cmd.cnt[2:0];

	always_comb begin
		case (cmd.push_src)
			shabsh_pkg::SRC_DATA: push_byte = data_byte;
			shabsh_pkg::SRC_MARK: push_byte = shabsh_pkg::PAD_MARK;
			shabsh_pkg::SRC_ZERO: push_byte = 8'h00;
			shabsh_pkg::SRC_LEN:  push_byte = count_q[{len_sel, 3'b000} +: 8];
			default:              push_byte = 8'h00;
		endcase
	end

	// schedule: next word from the 16-word window
	assign w_next = w_q[0]
		+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
		+ w_q[9]
		+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));

	// one compression round
	assign ea = v_q[4];
	assign aa = v_q[0];
	assign t1 = v_q[7] + (rotr(ea, 6) ^ rotr(ea, 11) ^ rotr(ea, 25))
		+ ((ea & v_q[5]) ^ (~ea & v_q[6]))
		+ shabsh_pkg::round_k(cmd.cnt) + w_q[0];
	assign t2 = (rotr(aa, 2) ^ rotr(aa, 13) ^ rotr(aa, 22))
		+ ((aa & v_q[1]) ^ (aa & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < shabsh_pkg::DIGEST_WORDS; i++) begin
				h_q[i] <= shabsh_pkg::init_h(shabsh_pkg::IDX_W'(i));
			end
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.hash_init) begin
				count_q <= '0;
			end else if (cmd.count_add) begin
				count_q <= count_q + 64'd8;
			end
			for (int i = 0; i < shabsh_pkg::DIGEST_WORDS; i++) begin
				if (cmd.hash_init) begin
					h_q[i] <= shabsh_pkg::init_h(shabsh_pkg::IDX_W'(i));
				end else if (cmd.hash_add) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_next;
		end else if (cmd.push) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= push_byte;
		end
		if (cmd.work_load) begin
			for (int i = 0; i < shabsh_pkg::DIGEST_WORDS; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

FILE: src/sha256_byte_stream_hasher_top.sv
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each append item brings one message byte and each
// finish item pads the message, runs the last compression(s) and returns the
// eight digest words as eight result items, word 0 first, last_word set on
// word 7; the next byte then starts a new message. An append byte goes straight
// into the block buffer, except that a byte completing a 64-byte block starts a
// compression (64 rounds at one per cycle in the single round unit, then a fold
// into the chaining hash), and the next item is not taken until it ends. A finish
// pushes padding one byte per cycle, save for a step that finds the length slot
// and pushes nothing and for any compression in between, runs one or two
// compressions, then offers one digest word per cycle while the output is not
// stalled.
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// top level: sequencer and datapath around the request and digest channels
// ---------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_top_assert.svh"

module sha256_byte_stream_hasher_top (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  shabsh_pkg::req_t  req,
	// digest channel
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output shabsh_pkg::rsp_t  rsp
);

	shabsh_pkg::cmd_t                cmd;
	shabsh_pkg::status_t             st;
	logic [shabsh_pkg::IDX_W-1:0]    word_index;
	logic                            last_word;
	logic [31:0]                     digest_word;

	// sequencer: owns the handshakes, the round counter and the padding phases
	shabsh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_type   (req.req_type),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.word_index (word_index),
		.last_word  (last_word),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: schedule window doubles as the block buffer
	shabsh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (req.data_byte),
		.cmd         (cmd),
		.st          (st),
		.digest_word (digest_word)
	);

	// digest item comes straight from the chaining hash registers, held while stalled
	assign rsp.digest_word = digest_word;
	assign rsp.word_index  = word_index;
	assign rsp.last_word   = last_word;

	// no request is taken while a digest is being read out
	`SHABSH_ASSERT_IMP(a_no_req_in_readout, rsp_valid, req_stall, "request taken during readout")
	// the buffer never gets a byte while the round unit runs
	`SHABSH_ASSERT_IMP(a_no_push_in_rounds, cmd.round_en, !cmd.push, "byte pushed during rounds")
	// after the final word is taken the digest channel falls idle
	`SHABSH_ASSERT_NXT(a_readout_ends, rsp_valid && !rsp_stall && rsp.last_word, !rsp_valid, "readout did not end")
	// each accepted non-final word is followed by the next word index
	`SHABSH_ASSERT_NXT(a_word_advance, rsp_valid && !rsp_stall && !rsp.last_word, rsp_valid && (rsp.word_index == shabsh_pkg::IDX_W'($past(rsp.word_index) + 1'b1)), "word index skipped")

endmodule
